### hw/rtl/cphp_pkg.sv
package cphp_pkg;

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_INCL      = 5'd1;
    localparam logic [4:0] PH_ZBP       = 5'd2;
    localparam logic [4:0] PH_NP_A      = 5'd3;
    localparam logic [4:0] PH_NP_B      = 5'd4;
    localparam logic [4:0] PH_NP_2      = 5'd5;
    localparam logic [4:0] PH_NP_5      = 5'd6;
    localparam logic [4:0] PH_NP_7      = 5'd7;
    localparam logic [4:0] PH_LBLK      = 5'd8;
    localparam logic [4:0] PH_HT_FIRST  = 5'd9;
    localparam logic [4:0] PH_HT_ZERO   = 5'd10;
    localparam logic [4:0] PH_HT_REREAD = 5'd11;
    localparam logic [4:0] PH_FIRST     = 5'd12;
    localparam logic [4:0] PH_LOOP_HT   = 5'd13;
    localparam logic [4:0] PH_LOOP      = 5'd14;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PASSES   = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_HT_LEN   = 3'd3;
    localparam logic [2:0] ST_CORRUPT  = 3'd4;

    localparam int STYLE_BYPASS  = 0;
    localparam int STYLE_TERMALL = 2;
    localparam int STYLE_HT      = 6;
    localparam int STYLE_MIXED   = 7;

    // The block index and block count fields fix the packet size limit.
    localparam int MAX_BLOCKS = 1024;

    localparam logic [7:0] STYLE_RESET      = 8'h40;
    localparam logic [7:0] BYPASS_THRESHOLD = 8'd10;
    localparam logic [5:0] LBLOCK_INIT      = 6'd3;
    localparam logic [5:0] LBLOCK_MAX       = 6'd63;
    localparam logic [3:0] ZBP_MAX          = 4'd14;

    localparam logic [0:0] REG_BLOCK_STYLE = 1'b0;

    // Number of passes fits in 8 bits; floor(log2) is at most 7.
    function automatic logic [2:0] flog2(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (v[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    // Remainder by three through a reciprocal multiply, exact for 8-bit inputs.
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 16'(v) * 16'd171;
        q = 8'(p >> 9);
        r = v - 8'(q * 8'd3);
        return r[1:0];
    endfunction

endpackage

### hw/rtl/codeblock_packet_header_parser_top.sv
// Packet header decoder for one quality layer of code-blocks, one header bit
// per transaction. Each bit goes through the parse logic between the state
// registers and an output register, so a new bit is accepted every cycle
// while the output register is empty or the sink takes its result. One result
// per code-block (one in all for an empty packet) appears the cycle after the
// bit that completes it; an error ends the packet. Write block_style only while
// no packet is being parsed.
module codeblock_packet_header_parser_top
    import cphp_pkg::*;
#(
    parameter int MAX_PASSES        = 100,
    parameter int LENGTH_LIMIT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [0] hdr_bit, [11:1] block_count
    input  logic        s_tuser,  // [0] packet_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // [9:0] block_index, [10] included,
                                  // [14:11] zero_bitplanes, [21:15] pass_count,
                                  // [37:22] cleanup_length, [57:38] data_length,
                                  // [60:58] status, [61] empty_packet
    output logic        m_tlast,  // last_of_packet
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  style_reg;
    logic [4:0]  phase_reg, phase_next;
    logic [9:0]  bcnt_reg, bcnt_next;
    logic [10:0] nblk_reg, nblk_next;
    logic [7:0]  done_reg, done_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  total_reg, total_next;
    logic [7:0]  segp_reg, segp_next;
    logic [5:0]  lb_reg, lb_next;
    logic [5:0]  fcnt_reg, fcnt_next;
    logic [5:0]  rw_reg, rw_next;
    logic [39:0] fval_reg, fval_next;
    logic [1:0]  nss_reg, nss_next;
    logic [7:0]  mode_reg, mode_next;
    logic        ph_reg, ph_next;
    logic        byp_reg, byp_next;
    logic [3:0]  zbp_reg, zbp_next;
    logic [15:0] clen_reg, clen_next;
    logic [19:0] rlen_reg, rlen_next;

    logic        ovalid_reg;
    logic [61:0] odata_reg;
    logic        olast_reg;

    logic        acc, bit_in, start;
    logic [10:0] cnt_in;
    logic        em;
    logic [2:0]  em_st;
    logic        em_incl, em_empty;
    logic        em_last;
    logic [9:0]  em_idx;
    logic [3:0]  em_zbp;
    logic [6:0]  em_done;
    logic [15:0] em_clen;
    logic [19:0] em_tot;
    logic        okf;
    logic [39:0] s;
    logic [5:0]  fc_dec;

    assign acc    = s_tvalid && s_tready;
    assign s_tready = !ovalid_reg || m_tready;
    assign bit_in = s_tdata[0];
    assign cnt_in = s_tdata[11:1];
    assign start  = s_tuser;
    assign pready = 1'b1;
    assign prdata = {24'd0, style_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            style_reg <= STYLE_RESET;
        end else if (psel && penable && pwrite && paddr == REG_BLOCK_STYLE) begin
            style_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        logic [7:0]  sp;
        logic [8:0]  sum9;
        logic [20:0] tsum;
        logic [20:0] osum;
        logic        accept, cont, commit, chk;
        logic [7:0]  t8;
        logic [10:0] c;
        phase_next = phase_reg; bcnt_next = bcnt_reg; nblk_next = nblk_reg;
        done_next = done_reg; pend_next = pend_reg; total_next = total_reg;
        segp_next = segp_reg; lb_next = lb_reg; fcnt_next = fcnt_reg;
        rw_next = rw_reg; fval_next = fval_reg; nss_next = nss_reg;
        mode_next = mode_reg; ph_next = ph_reg; byp_next = byp_reg;
        zbp_next = zbp_reg; clen_next = clen_reg; rlen_next = rlen_reg;
        em = 1'b0; em_st = ST_OK; em_incl = 1'b0; em_empty = 1'b0;
        em_last = 1'b0; em_idx = 10'd0; em_zbp = 4'd0; em_done = 7'd0;
        em_clen = 16'd0; em_tot = 20'd0;
        cont = 1'b0; commit = 1'b0; chk = 1'b0;
        sp = 8'd0; sum9 = 9'd0; tsum = 21'd0; osum = 21'd0; accept = 1'b0; t8 = 8'd0;
        c = 11'd0;
        s = {fval_reg[38:0], bit_in};
        fc_dec = (fcnt_reg != 6'd0) ? fcnt_reg - 6'd1 : 6'd0;

        if (start) begin
            c = cnt_in;
            if (c == 11'd0) c = 11'd1;
            if (32'(c) > MAX_BLOCKS) c = 11'(MAX_BLOCKS);
            nblk_next = c;
            bcnt_next = 10'd0;
            phase_next = PH_INCL;
            if (!bit_in) begin
                em = 1'b1; em_empty = 1'b1;
            end
        end else begin
            case (phase_reg)
                PH_INCL: begin
                    if (!bit_in) em = 1'b1;
                    else phase_next = PH_ZBP;
                end
                PH_ZBP: begin
                    if (!bit_in) begin
                        zbp_next = zbp_reg + 4'd1;
                        if (zbp_next >= ZBP_MAX) phase_next = PH_NP_A;
                    end else begin
                        phase_next = PH_NP_A;
                    end
                end
                PH_NP_A: begin
                    total_next = 8'd1 + 8'(bit_in);
                    if (bit_in) phase_next = PH_NP_B;
                    else chk = 1'b1;
                end
                PH_NP_B: begin
                    total_next = total_reg + 8'(bit_in);
                    if (bit_in) begin
                        rw_next = 6'd2; fcnt_next = 6'd2; fval_next = '0;
                        phase_next = PH_NP_2;
                    end else begin
                        chk = 1'b1;
                    end
                end
                PH_LBLK: begin
                    if (bit_in) begin
                        if (lb_reg < LBLOCK_MAX) lb_next = lb_reg + 6'd1;
                    end else if (32'(lb_reg) + 32'(flog2(total_reg))
                                 > LENGTH_LIMIT_BITS) begin
                        em = 1'b1; em_st = ST_LENGTH; em_incl = 1'b1;
                    end else begin
                        mode_next = style_reg;
                        ph_next = style_reg >= STYLE_RESET;
                        byp_next = 1'b0;
                        if (style_reg >= STYLE_RESET) begin
                            sp = total_reg - {6'd0, mod3(total_reg - 8'd1)};
                            phase_next = PH_HT_FIRST;
                        end else if (!style_reg[STYLE_TERMALL] && !style_reg[STYLE_BYPASS])
                        begin
                            sp = total_reg;
                            phase_next = PH_FIRST;
                        end else if (style_reg[STYLE_TERMALL]) begin
                            sp = 8'd1; nss_next = 2'd1;
                            phase_next = PH_FIRST;
                        end else begin
                            byp_next = 1'b1;
                            sp = (total_reg < BYPASS_THRESHOLD) ? total_reg
                                                                : BYPASS_THRESHOLD;
                            nss_next = 2'd2;
                            phase_next = PH_FIRST;
                        end
                        segp_next = sp;
                        rw_next = lb_reg + 6'(flog2(sp));
                        fcnt_next = rw_next; fval_next = '0;
                    end
                end
                PH_NP_2, PH_NP_5, PH_NP_7, PH_HT_FIRST, PH_HT_ZERO, PH_HT_REREAD,
                PH_FIRST, PH_LOOP_HT, PH_LOOP: begin
                    fval_next = s;
                    fcnt_next = fc_dec;
                    if (fc_dec == 6'd0) begin
                        case (phase_reg)
                            PH_NP_2: begin
                                total_next = total_reg + 8'(s[1:0]);
                                if (s[1:0] == 2'd3) begin
                                    rw_next = 6'd5; fcnt_next = 6'd5; fval_next = '0;
                                    phase_next = PH_NP_5;
                                end else chk = 1'b1;
                            end
                            PH_NP_5: begin
                                total_next = total_reg + 8'(s[4:0]);
                                if (s[4:0] == 5'd31) begin
                                    rw_next = 6'd7; fcnt_next = 6'd7; fval_next = '0;
                                    phase_next = PH_NP_7;
                                end else chk = 1'b1;
                            end
                            PH_NP_7: begin
                                total_next = total_reg + 8'(s[6:0]);
                                chk = 1'b1;
                            end
                            PH_HT_FIRST: begin
                                if (s != 40'd0) begin
                                    if (!mode_reg[STYLE_MIXED]) begin
                                        if (s < 40'd2) begin
                                            em = 1'b1; em_st = ST_HT_LEN; em_incl = 1'b1;
                                        end
                                        accept = 1'b1;
                                    end else begin
                                        accept = lb_reg > LBLOCK_INIT && s > 40'd1
                                                 && (s >> (rw_reg - 6'd1)) == 40'd0;
                                    end
                                    if (!em) begin
                                        ph_next = 1'b0;
                                        if (accept) begin
                                            nss_next = 2'd2;
                                            clen_next = (s > 40'hFFFF) ? 16'hFFFF : s[15:0];
                                            commit = 1'b1;
                                        end else begin
                                            mode_next[STYLE_HT] = 1'b0;
                                            rw_next = lb_reg + 6'(flog2(segp_reg));
                                            fcnt_next = rw_next; fval_next = '0;
                                            phase_next = PH_HT_REREAD;
                                        end
                                    end
                                end else begin
                                    segp_next = total_reg;
                                    rw_next = lb_reg + 6'(flog2(total_reg));
                                    fcnt_next = rw_next; fval_next = '0;
                                    phase_next = PH_HT_ZERO;
                                end
                            end
                            PH_HT_ZERO: begin
                                if (s != 40'd0 && !mode_reg[STYLE_MIXED]) begin
                                    em = 1'b1; em_st = ST_HT_LEN; em_incl = 1'b1;
                                end else begin
                                    if (s != 40'd0) begin
                                        mode_next[STYLE_HT] = 1'b0;
                                        ph_next = 1'b0;
                                    end
                                    commit = 1'b1;
                                end
                            end
                            PH_HT_REREAD, PH_FIRST: commit = 1'b1;
                            PH_LOOP_HT: begin
                                tsum = 21'(rlen_reg) + ((s > 40'hFFFFF) ? 21'hFFFFF
                                                                        : 21'(s[19:0]));
                                rlen_next = tsum[20] ? 20'hFFFFF : tsum[19:0];
                                done_next = done_reg + segp_reg;
                                pend_next = pend_reg - segp_reg;
                                cont = 1'b1;
                            end
                            default: begin
                                done_next = done_reg + segp_reg;
                                pend_next = pend_reg - segp_reg;
                                cont = 1'b1;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end

        if (chk) begin
            sum9 = {1'b0, done_reg} + {1'b0, total_next};
            if (32'(sum9) >= MAX_PASSES) begin
                em = 1'b1; em_st = ST_PASSES; em_incl = 1'b1;
            end else begin
                lb_next = LBLOCK_INIT;
                phase_next = PH_LBLK;
            end
        end

        if (commit) begin
            done_next = done_reg + segp_next;
            pend_next = total_reg - segp_next;
            cont = 1'b1;
        end

        if (cont) begin
            if (pend_next == 8'd0) begin
                em = 1'b1; em_incl = 1'b1;
            end else if ((mode_next[STYLE_HT] && !ph_next) || byp_next) begin
                t8 = (pend_next > 8'd1) ? {6'd0, nss_next} : 8'd1;
                segp_next = t8;
                nss_next = 2'd3 - nss_next;
                rw_next = lb_next + 6'(flog2(t8));
                fcnt_next = rw_next; fval_next = '0;
                phase_next = (mode_next[STYLE_HT] && !ph_next) ? PH_LOOP_HT : PH_LOOP;
            end else if (!mode_next[STYLE_TERMALL]) begin
                em = 1'b1; em_st = ST_CORRUPT; em_incl = 1'b1;
            end else begin
                segp_next = 8'd1;
                rw_next = lb_next; fcnt_next = lb_next; fval_next = '0;
                phase_next = PH_LOOP;
            end
        end

        if (em) begin
            // Capture the block's fields before the per-block state is cleared.
            em_last = em_st != ST_OK || em_empty
                      || {1'b0, bcnt_next} + 11'd1 >= nblk_next;
            em_idx  = bcnt_next;
            em_zbp  = zbp_next;
            em_done = done_next[6:0];
            em_clen = clen_next;
            osum    = 21'(clen_next) + 21'(rlen_next);
            em_tot  = osum[20] ? 20'hFFFFF : osum[19:0];
            if (em_last) begin
                phase_next = PH_IDLE;
            end else begin
                bcnt_next = bcnt_next + 10'd1;
                phase_next = PH_INCL;
            end
        end
        if (start || (em && phase_next == PH_INCL)) begin
            zbp_next = 4'd0; done_next = 8'd0; pend_next = 8'd0; total_next = 8'd0;
            clen_next = 16'd0; rlen_next = 20'd0; lb_next = LBLOCK_INIT;
            nss_next = 2'd0; ph_next = 1'b0; byp_next = 1'b0;
        end
    end

    assign okf = em_st == ST_OK && em_incl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; bcnt_reg <= '0; nblk_reg <= '0; done_reg <= '0;
            pend_reg <= '0; total_reg <= '0; segp_reg <= '0; lb_reg <= LBLOCK_INIT;
            fcnt_reg <= '0; rw_reg <= '0; fval_reg <= '0; nss_reg <= '0;
            mode_reg <= '0; ph_reg <= 1'b0; byp_reg <= 1'b0; zbp_reg <= '0;
            clen_reg <= '0; rlen_reg <= '0; ovalid_reg <= 1'b0;
        end else begin
            if (acc) begin
                phase_reg <= phase_next; bcnt_reg <= bcnt_next; nblk_reg <= nblk_next;
                done_reg <= done_next; pend_reg <= pend_next; total_reg <= total_next;
                segp_reg <= segp_next; lb_reg <= lb_next; fcnt_reg <= fcnt_next;
                rw_reg <= rw_next; fval_reg <= fval_next; nss_reg <= nss_next;
                mode_reg <= mode_next; ph_reg <= ph_next; byp_reg <= byp_next;
                zbp_reg <= zbp_next; clen_reg <= clen_next; rlen_reg <= rlen_next;
            end
            if (acc && em) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
    end

    // The emitted fields come from the state as it stood before the per-block
    // reset, so they are captured from the pre-reset values.
    always_ff @(posedge aclk) begin
        if (acc && em) begin
            odata_reg[9:0]   <= em_idx;
            odata_reg[10]    <= em_incl;
            odata_reg[14:11] <= em_incl ? em_zbp : 4'd0;
            odata_reg[21:15] <= okf ? em_done : 7'd0;
            odata_reg[37:22] <= okf ? em_clen : 16'd0;
            odata_reg[57:38] <= okf ? em_tot : 20'd0;
            odata_reg[60:58] <= em_st;
            odata_reg[61]    <= em_empty;
            olast_reg        <= em_last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'd0, odata_reg};
    assign m_tlast  = olast_reg;

endmodule

### tb/codeblock_packet_header_parser_top_test.sv
`timescale 1ns / 100ps

module codeblock_packet_header_parser_top_test
    import cphp_pkg::*;
();

    localparam int unsigned PASS_LIMIT = 100;
    localparam int unsigned LEN_LIMIT  = 16;
    localparam int unsigned BLK_LIMIT  = 1024;

    typedef struct {
        bit         hbit;
        bit         pstart;
        logic [10:0] count;
    } hdr_item_t;

    typedef struct {
        logic [9:0]  idx;
        logic        incl;
        logic [3:0]  zbp;
        logic [6:0]  npass;
        logic [15:0] clen;
        logic [19:0] dlen;
        logic [2:0]  status;
        logic        empty;
        logic        last;
    } blk_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;  // [0] hdr_bit, [11:1] block_count
    logic        s_tuser;  // [0] packet_start
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;  // [9:0] block_index, [10] included, [14:11] zero_bitplanes,
                           // [21:15] pass_count, [37:22] cleanup_length,
                           // [57:38] data_length, [60:58] status, [61] empty_packet
    logic        m_tlast;  // last_of_packet
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    codeblock_packet_header_parser_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hdr_item_t   bit_q[$];
    blk_result_t block_expect_q[$];
    hdr_item_t   cur_item;
    int          mismatches;
    int          cyc;
    bit          run;
    bit          in_fire;
    bit          hold_req;
    int          hold_cnt;
    bit          zlow;
    int          lblk_run;

    // Shadow state of the header parser.
    logic [7:0]      style_reg;
    logic [4:0]      ph;
    logic [7:0]      mflags;
    int unsigned     blk, nblk, pdone, ppend, lbb, fcnt, nseg, phold, byp;
    int unsigned     zbp, clen, rlen, ptot, segp, rw;
    longint unsigned fval;

    function automatic int unsigned lg2(int unsigned v);
        int unsigned r;
        r = 0;
        while (v > 1) begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic void begin_field(int unsigned width, logic [4:0] nxt);
        rw   = width;
        fcnt = width;
        fval = 0;
        ph   = nxt;
    endfunction

    function automatic void fresh_block();
        zbp   = 0;
        pdone = 0;
        ppend = 0;
        ptot  = 0;
        clen  = 0;
        rlen  = 0;
        lbb   = 3;
        nseg  = 0;
        phold = 0;
        byp   = 0;
        ph    = PH_INCL;
    endfunction

    function automatic void post_block(logic [2:0] st, bit incl, bit empty);
        blk_result_t     r;
        bit              last;
        bit              ok;
        longint unsigned tot;
        last = (st != ST_OK) || empty || (blk + 1 >= nblk);
        ok   = (st == ST_OK) && incl;
        tot  = longint'(clen) + longint'(rlen);
        if (tot > 64'hFFFFF) begin
            tot = 64'hFFFFF;
        end
        r.idx    = blk[9:0];
        r.incl   = incl;
        r.zbp    = incl ? zbp[3:0] : 4'd0;
        r.npass  = ok ? pdone[6:0] : 7'd0;
        r.clen   = ok ? clen[15:0] : 16'd0;
        r.dlen   = ok ? tot[19:0] : 20'd0;
        r.status = st;
        r.empty  = empty;
        r.last   = last;
        block_expect_q.push_back(r);
        if (last) begin
            ph = PH_IDLE;
        end else begin
            blk++;
            fresh_block();
        end
    endfunction

    function automatic void next_segment();
        if (ppend == 0) begin
            post_block(ST_OK, 1, 0);
        end else if (mflags[STYLE_HT] && phold == 0) begin
            segp = (ppend > 1) ? nseg : 1;
            nseg = 3 - nseg;
            begin_field(lbb + lg2(segp), PH_LOOP_HT);
        end else if (byp != 0) begin
            segp = (ppend > 1) ? nseg : 1;
            nseg = 3 - nseg;
            begin_field(lbb + lg2(segp), PH_LOOP);
        end else if (!mflags[STYLE_TERMALL]) begin
            post_block(ST_CORRUPT, 1, 0);
        end else begin
            segp = 1;
            begin_field(lbb, PH_LOOP);
        end
    endfunction

    function automatic void commit_first_segment();
        pdone += segp;
        ppend = ptot - segp;
        next_segment();
    endfunction

    function automatic void check_pass_total();
        if (pdone + ptot >= PASS_LIMIT) begin
            post_block(ST_PASSES, 1, 0);
        end else begin
            lbb = 3;
            ph  = PH_LBLK;
        end
    endfunction

    function automatic void start_lengths();
        mflags = style_reg;
        phold  = (mflags >= 8'h40) ? 1 : 0;
        byp    = 0;
        if (phold != 0) begin
            segp = ptot - (ptot - 1) % 3;
            begin_field(lbb + lg2(segp), PH_HT_FIRST);
        end else if (!mflags[STYLE_TERMALL] && !mflags[STYLE_BYPASS]) begin
            segp = ptot;
            begin_field(lbb + lg2(segp), PH_FIRST);
        end else if (mflags[STYLE_TERMALL]) begin
            segp = 1;
            nseg = 1;
            begin_field(lbb, PH_FIRST);
        end else begin
            byp  = 1;
            segp = (ptot < 10) ? ptot : 10;
            nseg = 2;
            begin_field(lbb + lg2(segp), PH_FIRST);
        end
    endfunction

    function automatic void parse_bit(bit b, bit st, logic [10:0] cnt);
        int unsigned     c;
        longint unsigned s;
        bit              acc;
        if (st) begin
            c = 32'(cnt);
            if (c == 0) c = 1;
            if (c > BLK_LIMIT) c = BLK_LIMIT;
            nblk = c;
            blk  = 0;
            fresh_block();
            if (!b) post_block(ST_OK, 0, 1);
            return;
        end
        case (ph)
            PH_IDLE: return;
            PH_INCL: begin
                if (!b) post_block(ST_OK, 0, 0);
                else ph = PH_ZBP;
                return;
            end
            PH_ZBP: begin
                if (!b) begin
                    zbp++;
                    if (zbp < 14) return;
                end
                ph = PH_NP_A;
                return;
            end
            PH_NP_A: begin
                ptot = 1 + b;
                if (b) ph = PH_NP_B;
                else check_pass_total();
                return;
            end
            PH_NP_B: begin
                ptot += b;
                if (b) begin_field(2, PH_NP_2);
                else check_pass_total();
                return;
            end
            PH_LBLK: begin
                if (b) begin
                    if (lbb < 63) lbb++;
                end else if (lbb + lg2(ptot) > LEN_LIMIT) begin
                    post_block(ST_LENGTH, 1, 0);
                end else begin
                    start_lengths();
                end
                return;
            end
            default: ;
        endcase

        fval = ((fval << 1) | b) & 64'hFF_FFFF_FFFF;
        if (fcnt > 0) fcnt--;
        if (fcnt != 0) return;
        s = fval;

        case (ph)
            PH_NP_2: begin
                ptot += 32'(s);
                if (s == 3) begin_field(5, PH_NP_5);
                else check_pass_total();
            end
            PH_NP_5: begin
                ptot += 32'(s);
                if (s == 31) begin_field(7, PH_NP_7);
                else check_pass_total();
            end
            PH_NP_7: begin
                ptot += 32'(s);
                check_pass_total();
            end
            PH_HT_FIRST: begin
                if (s != 0) begin
                    if (!mflags[STYLE_MIXED]) begin
                        if (s < 2) begin
                            post_block(ST_HT_LEN, 1, 0);
                            return;
                        end
                        acc = 1;
                    end else begin
                        acc = (lbb > 3) && (s > 1) && ((s >> (rw - 1)) == 0);
                    end
                    if (acc) begin
                        nseg  = 2;
                        phold = 0;
                        clen  = (s > 65535) ? 65535 : 32'(s);
                        commit_first_segment();
                    end else begin
                        mflags[STYLE_HT] = 1'b0;
                        phold = 0;
                        begin_field(lbb + lg2(segp), PH_HT_REREAD);
                    end
                end else begin
                    segp = ptot;
                    begin_field(lbb + lg2(segp), PH_HT_ZERO);
                end
            end
            PH_HT_ZERO: begin
                if (s != 0) begin
                    if (!mflags[STYLE_MIXED]) begin
                        post_block(ST_HT_LEN, 1, 0);
                        return;
                    end
                    mflags[STYLE_HT] = 1'b0;
                    phold = 0;
                end
                commit_first_segment();
            end
            PH_HT_REREAD, PH_FIRST: commit_first_segment();
            PH_LOOP_HT: begin
                s = s + rlen;
                rlen = (s > 64'hFFFFF) ? 32'hFFFFF : 32'(s);
                pdone += segp;
                ppend -= segp;
                next_segment();
            end
            default: begin
                pdone += segp;
                ppend -= segp;
                next_segment();
            end
        endcase
    endfunction

    function automatic void put(bit b, bit st, logic [10:0] cnt);
        hdr_item_t it;
        it.hbit   = b;
        it.pstart = st;
        it.count  = cnt;
        bit_q.push_back(it);
        parse_bit(b, st, cnt);
    endfunction

    // Bias each header bit by the parse state so that most blocks decode in full.
    function automatic bit pick_bit();
        case (ph)
            PH_INCL: begin
                zlow = ($urandom_range(3) == 0);
                if ($urandom_range(24) == 0) lblk_run = 66;
                return $urandom_range(99) < 85;
            end
            PH_ZBP: return $urandom_range(99) < (zlow ? 4 : 45);
            PH_NP_A, PH_NP_B, PH_NP_2, PH_NP_5, PH_NP_7: return 1'($urandom_range(1));
            PH_LBLK: begin
                if (lblk_run > 0) begin
                    lblk_run--;
                    return 1'b1;
                end
                return $urandom_range(99) < 30;
            end
            default: return $urandom_range(99) < 35;
        endcase
    endfunction

    task automatic wait_drained();
        while (bit_q.size() != 0 || block_expect_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_style(logic [7:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_BLOCK_STYLE;
        pwdata  <= {24'h0, v};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        style_reg = v;
    endtask

    task automatic run_packets(int n, bit pause_mid);
        int k;
        int c;
        k = 0;
        while (k < n || ph != PH_IDLE) begin
            if (pause_mid && k == n / 2) begin
                wait_drained();
                pause_mid = 0;
            end
            if (ph == PH_IDLE) begin
                if ($urandom_range(99) < 5) begin
                    put(1'($urandom_range(1)), 0, 11'($urandom));
                end else begin
                    c = ($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(2047);
                    put((c <= 4) ? ($urandom_range(99) < 90) : 1'b0, 1, 11'(c));
                    k++;
                end
            end else if ($urandom_range(99) == 0) begin
                put(1'($urandom_range(1)), 1, 11'($urandom_range(1, 4)));
                k++;
            end else begin
                put(pick_bit(), 0, 11'($urandom));
                k++;
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("** codeblock_packet_header_parser_top: FAILED **");
        $finish;
    end

    always @(posedge aclk) begin
        cyc++;
        in_fire  = s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        if (s_tvalid && !in_fire) begin
            // Transaction still waiting for acceptance; hold it.
        end else if (run && bit_q.size() > 0
                     && ((cyc >= 1500 && cyc < 2100) || $urandom_range(99) >= 36)) begin
            cur_item = bit_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {4'h0, cur_item.count, cur_item.hbit};
            s_tuser  <= cur_item.pstart;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (cyc >= 1500 && cyc < 2100) || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge aclk) begin
        blk_result_t got;
        blk_result_t want;
        if (m_tvalid && m_tready) begin
            got.idx    = m_tdata[9:0];
            got.incl   = m_tdata[10];
            got.zbp    = m_tdata[14:11];
            got.npass  = m_tdata[21:15];
            got.clen   = m_tdata[37:22];
            got.dlen   = m_tdata[57:38];
            got.status = m_tdata[60:58];
            got.empty  = m_tdata[61];
            got.last   = m_tlast;
            if (block_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction: %p", got);
            end else begin
                want = block_expect_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("block result mismatch at %0t", $realtime);
                        $display("  expected %p", want);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    initial begin
        logic [7:0] styles [9];
        styles = '{8'h00, 8'h01, 8'h04, 8'h05, 8'hC0, 8'h80, 8'hFF, 8'h41, 8'h00};
        styles[8] = 8'($urandom_range(255));
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        run      = 1'b0;
        in_fire  = 1'b0;
        hold_req = 1'b0;
        hold_cnt = 0;
        lblk_run = 0;
        cyc      = 0;
        mismatches = 0;

        style_reg = STYLE_RESET;
        blk  = 0;
        nblk = 0;
        fcnt = 0;
        fval = 0;
        mflags = 0;
        rw   = 0;
        segp = 0;
        fresh_block();
        ph = PH_IDLE;

        // Stray bits outside a packet, empty packets with out-of-range counts,
        // a restart after a skipped block, and a pass count over the limit.
        put(1, 0, 11'h7FF);
        put(0, 0, 11'h000);
        put(0, 1, 11'd0);
        put(0, 1, 11'h7FF);
        put(1, 1, 11'd1024);
        put(0, 0, 11'h555);
        put(0, 1, 11'h555);
        put(1, 1, 11'h2AA);
        put(0, 1, 11'h2AA);
        put(1, 1, 11'd1);
        put(1, 0, 0);
        put(1, 0, 0);
        repeat (4) put(1, 0, 0);
        repeat (14) put(1, 0, 0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        run = 1'b1;
        wait_drained();

        hold_req = 1'b1;
        run_packets(52, 0);
        wait_drained();
        foreach (styles[i]) begin
            write_style(styles[i]);
            run_packets(52, styles[i] == 8'hC0);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("** codeblock_packet_header_parser_top: PASSED **");
        end else begin
            $display("** codeblock_packet_header_parser_top: FAILED **");
        end
        $finish;
    end

endmodule
